/* sv/line_assembler_with_line_queue_macros.svh */
// Assertion macros for the line assembler with line queue.
// Used by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef LINE_ASSEMBLER_WITH_LINE_QUEUE_MACROS_SVH
`define LINE_ASSEMBLER_WITH_LINE_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LAQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define LAQ_ASSERT_NEVER(lbl, cond, msg) \
  `LAQ_ASSERT(lbl, !(cond), msg)
`else
`define LAQ_ASSERT(lbl, prop, msg)
`define LAQ_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/lasm_pkg.sv */
// Shared types and constants of the line assembler with line queue.
// No dependencies; used by the top level line_assembler_with_line_queue.
`timescale 1ns / 1ps

package lasm_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  // Line terminators
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam int unsigned MaxLenW = 7;
  localparam int unsigned DropW   = 32;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         rx_byte;
    logic [MaxLenW-1:0] max_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       ch;
    logic             has_char;
    logic             last;
    logic             queue_was_empty;
    logic             line_ready;
    logic [DropW-1:0] dropped_count;
  } out_item_t;

endpackage

/* sv/line_assembler_with_line_queue.sv */
// Top level of the line assembler with line queue: control, ring pointers, output stage.
// Depends on lasm_pkg, lasm_ram and line_assembler_with_line_queue_macros.svh.
`timescale 1ns / 1ps
`include "line_assembler_with_line_queue_macros.svh"

// Usage
// - Input channel (in_valid_i / in_ready_o / in_item_i) carries one command per item:
//   a received byte, a pop of the oldest line, or a status query.
// - Output channel (out_valid_o / out_ready_i / out_item_o) returns the result items.
// - A received byte returns nothing; it is written straight into the line-store row
//   of the free slot at wr_slot, so a terminator only commits the length and
//   advances the ring pointer.
// - A status query, or a pop on an empty ring, returns one item from the output
//   register.
// - A pop reads the slot length, then streams one character per cycle, while the
//   receiver does not stall, from the line-store RAM (registered read) through a read
//   stage into the output register; the input side stays busy until the last
//   character has left the read stage.
// - The line-store RAM read port sets the streaming rate: one character per cycle unless stalled.
// - When the receiver stalls, the output register and the read stage hold; reads stop
//   and resume without loss. Input is taken again once all results are staged.
// - Reset clears pointers, build length and drop counter; RAM contents are undefined
//   and never read before being written, so no clearing pass runs.
module line_assembler_with_line_queue #(
  parameter int unsigned QUEUE_SLOTS = 8,
  parameter int unsigned LINE_MAX    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lasm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lasm_pkg::out_item_t out_item_o
);

  localparam int unsigned SW     = $clog2(QUEUE_SLOTS);
  localparam int unsigned LW     = $clog2(LINE_MAX);
  localparam int unsigned SDEPTH = QUEUE_SLOTS * (2 ** LW);
  localparam int unsigned MLW    = lasm_pkg::MaxLenW;

  localparam logic [SW-1:0] LastSlot = SW'(QUEUE_SLOTS - 1);
  localparam logic [LW-1:0] MaxBlen  = LW'(LINE_MAX - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LEN    = 4'b0010,
    ST_STREAM = 4'b0100,
    ST_SINGLE = 4'b1000
  } state_e;

  // Control state
  state_e                     state_q, state_d;
  logic [SW-1:0]              wr_slot_q, wr_slot_d;
  logic [SW-1:0]              rd_slot_q, rd_slot_d;
  logic [LW-1:0]              blen_q, blen_d;
  logic [lasm_pkg::DropW-1:0] drop_q, drop_d;
  logic                       a_valid_q, a_valid_d;
  logic                       out_valid_q, out_valid_d;

  // Payload state
  logic [MLW-1:0]      max_len_q, max_len_d;
  logic [SW-1:0]       pop_slot_q, pop_slot_d;
  logic [LW-1:0]       n_q, n_d;
  logic [LW-1:0]       idx_q, idx_d;
  logic                a_last_q, a_last_d;
  logic                single_empty_q, single_empty_d;
  lasm_pkg::out_item_t out_q, out_d;

  // RAM ports
  logic             store_we, store_re;
  logic [SW+LW-1:0] store_waddr, store_raddr;
  logic [7:0]       store_rdata;
  logic             len_we, len_re;
  logic [LW-1:0]    len_rdata;

  logic           in_fire, b_ready, a_ready, q_empty, is_term, single_load, single_flag;
  logic [SW-1:0]  wr_next, rd_next;
  logic [MLW-1:0] cap, len_ext, n_ext;

  assign in_ready_o = (state_q == ST_IDLE) && !a_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b_ready    = !out_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign q_empty    = (wr_slot_q == rd_slot_q);
  assign wr_next    = (wr_slot_q == LastSlot) ? '0 : wr_slot_q + SW'(1);
  assign rd_next    = (rd_slot_q == LastSlot) ? '0 : rd_slot_q + SW'(1);
  assign is_term    = (in_item_i.rx_byte == lasm_pkg::CH_LF) ||
                      (in_item_i.rx_byte == lasm_pkg::CH_CR) ||
                      (in_item_i.rx_byte == lasm_pkg::CH_HASH);

  // Byte path: the free slot at wr_slot doubles as the build buffer
  assign store_we    = in_fire && (in_item_i.cmd == lasm_pkg::CMD_BYTE) && !is_term &&
                       (blen_q != MaxBlen);
  assign store_waddr = {wr_slot_q, blen_q};
  assign len_we      = in_fire && (in_item_i.cmd == lasm_pkg::CMD_BYTE) && is_term &&
                       (blen_q != '0) && (wr_next != rd_slot_q);
  assign len_re      = in_fire && (in_item_i.cmd == lasm_pkg::CMD_POP) && !q_empty;

  // Number of characters to send: min(length, max_len - 1), max_len of 0 acts as 1
  assign cap     = (max_len_q == '0) ? '0 : max_len_q - MLW'(1);
  assign len_ext = MLW'(len_rdata);
  assign n_ext   = (len_ext < cap) ? len_ext : cap;

  assign store_re    = (state_q == ST_STREAM) && a_ready;
  assign store_raddr = {pop_slot_q, idx_q};

  always_comb begin
    state_d        = state_q;
    wr_slot_d      = wr_slot_q;
    rd_slot_d      = rd_slot_q;
    blen_d         = blen_q;
    drop_d         = drop_q;
    max_len_d      = max_len_q;
    pop_slot_d     = pop_slot_q;
    n_d            = n_q;
    idx_d          = idx_q;
    a_last_d       = a_last_q;
    single_empty_d = single_empty_q;
    single_load    = 1'b0;
    single_flag    = single_empty_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_item_i.cmd)
            lasm_pkg::CMD_BYTE: begin
              if (is_term) begin
                if (blen_q != '0) begin
                  if (wr_next == rd_slot_q) begin
                    drop_d = drop_q + lasm_pkg::DropW'(1);
                  end else begin
                    wr_slot_d = wr_next;
                  end
                end
                blen_d = '0;
              end else if (blen_q != MaxBlen) begin
                blen_d = blen_q + LW'(1);
              end else begin
                // overlong line: drop it
                blen_d = '0;
              end
            end
            lasm_pkg::CMD_POP: begin
              if (q_empty) begin
                single_flag    = 1'b1;
                single_empty_d = 1'b1;
                single_load    = b_ready;
                state_d        = b_ready ? ST_IDLE : ST_SINGLE;
              end else begin
                // free the slot now; line_ready of every result reflects it
                rd_slot_d  = rd_next;
                pop_slot_d = rd_slot_q;
                max_len_d  = in_item_i.max_len;
                state_d    = ST_LEN;
              end
            end
            lasm_pkg::CMD_STATUS: begin
              single_flag    = 1'b0;
              single_empty_d = 1'b0;
              single_load    = b_ready;
              state_d        = b_ready ? ST_IDLE : ST_SINGLE;
            end
            default: begin
              // unknown command: ignore
            end
          endcase
        end
      end
      ST_LEN: begin
        n_d   = LW'(n_ext);
        idx_d = '0;
        if (n_ext == '0) begin
          single_empty_d = 1'b0;
          state_d        = ST_SINGLE;
        end else begin
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (store_re) begin
          a_last_d = (idx_q == n_q - LW'(1));
          idx_d    = idx_q + LW'(1);
          if (idx_q == n_q - LW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (b_ready && !a_valid_q) begin
          single_load = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Read stage and output register
  always_comb begin
    a_valid_d   = a_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (store_re) begin
      a_valid_d = 1'b1;
    end else if (b_ready) begin
      a_valid_d = 1'b0;
    end
    if (a_valid_q && b_ready) begin
      out_valid_d           = 1'b1;
      out_d.ch              = store_rdata;
      out_d.has_char        = 1'b1;
      out_d.last            = a_last_q;
      out_d.queue_was_empty = 1'b0;
      out_d.line_ready      = !q_empty;
      out_d.dropped_count   = drop_q;
    end else if (single_load) begin
      out_valid_d           = 1'b1;
      out_d.ch              = '0;
      out_d.has_char        = 1'b0;
      out_d.last            = 1'b1;
      out_d.queue_was_empty = single_flag;
      out_d.line_ready      = !q_empty;
      out_d.dropped_count   = drop_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      blen_q      <= '0;
      drop_q      <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_slot_q   <= wr_slot_d;
      rd_slot_q   <= rd_slot_d;
      blen_q      <= blen_d;
      drop_q      <= drop_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_len_q      <= max_len_d;
    pop_slot_q     <= pop_slot_d;
    n_q            <= n_d;
    idx_q          <= idx_d;
    a_last_q       <= a_last_d;
    single_empty_q <= single_empty_d;
    out_q          <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  lasm_ram #(
    .DEPTH (SDEPTH),
    .WIDTH (8)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (in_item_i.rx_byte),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  lasm_ram #(
    .DEPTH (QUEUE_SLOTS),
    .WIDTH (LW)
  ) u_line_lengths (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (wr_slot_q),
    .wdata_i (blen_q),
    .re_i    (len_re),
    .raddr_i (rd_slot_q),
    .rdata_o (len_rdata)
  );

  `LAQ_ASSERT_NEVER(a_store_row_clash, store_we && store_re && (wr_slot_q == pop_slot_q), "line store read and write hit the same slot row")
  `LAQ_ASSERT(a_slots_in_range, (32'(wr_slot_q) < QUEUE_SLOTS) && (32'(rd_slot_q) < QUEUE_SLOTS), "ring pointer out of range")
  `LAQ_ASSERT(a_stream_index, (state_q != ST_STREAM) || ((idx_q < n_q) && (n_q != '0)), "stream index past line length")
  `LAQ_ASSERT(a_pop_advances, len_re |=> (rd_slot_q != $past(rd_slot_q)), "pop did not free its slot")
  `LAQ_ASSERT_NEVER(a_stage_order, single_load && a_valid_q, "single result overtook a streamed character")

endmodule

/* sv/lasm_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Read data holds while no read is issued. Depends on nothing.
`timescale 1ns / 1ps

module lasm_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
